// ----- design/iqdc_pkg.sv -----
// Shared types and constants for the I/Q DC removal and AGC front end.
`default_nettype none

package iqdc_pkg;

  localparam int STRENGTH_MAX = 8191;
  // Radix-4 restoring divider: two quotient bits per step over a 16-bit dividend.
  localparam int DIV_STEPS    = 8;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REG_AGC_TOP    = 2'd0,
    REG_AUDIO_GAIN = 2'd1,
    REG_OR_THRESH  = 2'd2,
    REG_OR_ENABLE  = 2'd3
  } reg_idx_t;

  localparam logic [14:0] AGC_TOP_RST    = 15'd150;
  localparam logic [7:0]  AUDIO_GAIN_RST = 8'd100;
  localparam logic [10:0] OR_THRESH_RST  = 11'd150;
  localparam logic        OR_ENABLE_RST  = 1'b1;

  typedef struct packed {
    logic [11:0] raw_i;
    logic [11:0] raw_q;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] scaled_i;
    logic signed [15:0] scaled_q;
    logic               ovr_flag;
    logic [12:0]        signal_strength;
    logic [14:0]        agc_scale;
  } out_item_t;

  typedef struct packed {
    logic [14:0] agc_top;
    logic [7:0]  audio_gain;
    logic [10:0] ovr_thresh;
    logic        ovr_enable;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture input transfer
    logic upd;       // update bias accumulators
    logic rem;       // form bias-removed samples
    logic mag;       // magnitude estimate, divider init
    logic div_step;  // one radix-4 divide step
    logic gain;      // gain * scale
    logic emit;      // final multiply into output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ----- design/iq_dc_removal_agc_frontend.sv -----
// Top level of the I/Q DC removal and AGC front end.
`default_nettype none

// Takes one 12-bit I/Q sample pair per input transfer and gives one result
// per transfer: both channels with their running DC bias removed, scaled by
// audio_gain * (agc_top / magnitude) and wrapped to 16 bits, together with the
// over-range flag, the magnitude estimate and the AGC scale. Samples are
// processed one at a time; each item passes through the input transfer,
// bias update, bias removal, magnitude, the 8-step radix-4 divider that
// forms the scale, gain and the final multiply before the next input
// transfer. The result sits in an output register, so the next sample is
// taken while it waits; a stalled output holds the sequencer at its final
// multiply. Configuration registers sit at byte offsets 0, 4, 8 and 12 and
// should only be written while no sample is in flight.
module iq_dc_removal_agc_frontend #(
  parameter int BIAS_SHIFT   = 8,
  parameter int ADC_MIDSCALE = 2048
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire iqdc_pkg::in_item_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output iqdc_pkg::out_item_t              out_data,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [iqdc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [iqdc_pkg::DATA_W-1:0] pwdata,
  output logic      [iqdc_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);
  import iqdc_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  iqdc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  iqdc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  iqdc_datapath #(
    .BIAS_SHIFT   (BIAS_SHIFT),
    .ADC_MIDSCALE (ADC_MIDSCALE)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .cfg       (cfg),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule

`default_nettype wire

// ----- design/iqdc_regs.sv -----
// APB-style configuration register file.
`default_nettype none

module iqdc_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [iqdc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [iqdc_pkg::DATA_W-1:0] pwdata,
  output logic      [iqdc_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output iqdc_pkg::cfg_t                  cfg
);
  import iqdc_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.agc_top    <= AGC_TOP_RST;
      cfg_r.audio_gain <= AUDIO_GAIN_RST;
      cfg_r.ovr_thresh <= OR_THRESH_RST;
      cfg_r.ovr_enable <= OR_ENABLE_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_AGC_TOP:    cfg_r.agc_top    <= pwdata[14:0];
        REG_AUDIO_GAIN: cfg_r.audio_gain <= pwdata[7:0];
        REG_OR_THRESH:  cfg_r.ovr_thresh <= pwdata[10:0];
        REG_OR_ENABLE:  cfg_r.ovr_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_AGC_TOP:    prdata = {17'd0, cfg_r.agc_top};
      REG_AUDIO_GAIN: prdata = {24'd0, cfg_r.audio_gain};
      REG_OR_THRESH:  prdata = {21'd0, cfg_r.ovr_thresh};
      REG_OR_ENABLE:  prdata = {31'd0, cfg_r.ovr_enable};
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/iqdc_ctrl.sv -----
// Sequencing state machine for the front end.
`default_nettype none

module iqdc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire iqdc_pkg::status_t status,
  output iqdc_pkg::cmd_t         cmd
);
  import iqdc_pkg::*;

  localparam int              CNT_W    = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_UPD  = 7'b0000010,
    S_REM  = 7'b0000100,
    S_MAG  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_GAIN = 7'b0100000,
    S_MULT = 7'b1000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_REM;
      end
      S_REM: begin
        cmd.rem   = 1'b1;
        state_nxt = S_MAG;
      end
      S_MAG: begin
        cmd.mag   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_GAIN;
        end
      end
      S_GAIN: begin
        cmd.gain  = 1'b1;
        state_nxt = S_MULT;
      end
      S_MULT: begin
        // hold until the output register can take the result
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_mag_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MAG |=> state_r == S_DIV && cnt_r == '0)
    else $error("divide did not start after magnitude");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV && cnt_r == DIV_LAST |=> state_r == S_GAIN)
    else $error("divide ran past its last step");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> status.out_free)
    else $error("result emitted over a pending transfer");

endmodule

`default_nettype wire

// ----- design/iqdc_datapath.sv -----
// Bias removal, magnitude, divider, gain multiply and output register.
`default_nettype none

module iqdc_datapath #(
  parameter int BIAS_SHIFT   = 8,
  parameter int ADC_MIDSCALE = 2048
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire iqdc_pkg::cmd_t     cmd,
  output iqdc_pkg::status_t       status,
  input  wire iqdc_pkg::cfg_t     cfg,
  input  wire iqdc_pkg::in_item_t in_data,
  output iqdc_pkg::out_item_t     out_data,
  output logic                    out_valid,
  input  wire logic               out_ready
);
  import iqdc_pkg::*;

  localparam logic [31:0] ACC_RESET = 32'(ADC_MIDSCALE) << BIAS_SHIFT;

  logic [31:0] acc_i_r, acc_q_r, acc_i_nxt, acc_q_nxt;
  logic [11:0] raw_i_r, raw_q_r;
  logic [15:0] si_r, sq_r;
  logic        over_r;
  logic [12:0] strength_r;
  logic [15:0] quo_r;
  logic [12:0] rem_r;
  logic [14:0] scale_r;
  logic [15:0] gs_r;
  out_item_t   out_r;
  logic        out_valid_r, out_valid_nxt;

  // bias estimate and sample minus estimate (low 16 bits are all that matter)
  logic signed [31:0] est_i, est_q;
  logic [15:0]        diff_i, diff_q;

  assign est_i  = $signed(acc_i_r) >>> BIAS_SHIFT;
  assign est_q  = $signed(acc_q_r) >>> BIAS_SHIFT;
  assign diff_i = {4'd0, raw_i_r} - est_i[15:0];
  assign diff_q = {4'd0, raw_q_r} - est_q[15:0];

  assign acc_i_nxt = acc_i_r + {{16{diff_i[15]}}, diff_i};
  assign acc_q_nxt = acc_q_r + {{16{diff_q[15]}}, diff_q};

  // alpha max + beta min
  logic [15:0] abs_i, abs_q, mx, mn;
  logic [17:0] mn3;
  logic [16:0] mag_sum;
  logic [12:0] strength_nxt;

  assign abs_i   = si_r[15] ? 16'd0 - si_r : si_r;
  assign abs_q   = sq_r[15] ? 16'd0 - sq_r : sq_r;
  assign mx      = (abs_i > abs_q) ? abs_i : abs_q;
  assign mn      = (abs_i > abs_q) ? abs_q : abs_i;
  assign mn3     = {2'd0, mn} + {1'b0, mn, 1'b0};
  assign mag_sum = {1'b0, mx} + {2'd0, mn3[17:3]};

  always_comb begin
    if (mag_sum > 17'(STRENGTH_MAX)) begin
      strength_nxt = 13'(STRENGTH_MAX);
    end else if (mag_sum == '0) begin
      strength_nxt = 13'd1;
    end else begin
      strength_nxt = mag_sum[12:0];
    end
  end

  // two restoring steps per cycle
  logic [13:0] dvs, t1, t2, r1, r2;
  logic        ge1, ge2;

  assign dvs = {1'b0, strength_r};
  assign t1  = {rem_r, quo_r[15]};
  assign ge1 = (t1 >= dvs);
  assign r1  = ge1 ? t1 - dvs : t1;
  assign t2  = {r1[12:0], quo_r[14]};
  assign ge2 = (t2 >= dvs);
  assign r2  = ge2 ? t2 - dvs : t2;

  logic [14:0] scale_nxt;
  logic [22:0] gs_full;
  logic [31:0] prod_i, prod_q;

  assign scale_nxt = (quo_r[14:0] == '0) ? 15'd1 : quo_r[14:0];
  assign gs_full   = {15'd0, cfg.audio_gain} * {8'd0, scale_nxt};
  // only the low 16 bits of the product survive, so signedness drops out
  assign prod_i    = {16'd0, si_r} * {16'd0, gs_r};
  assign prod_q    = {16'd0, sq_r} * {16'd0, gs_r};

  assign out_valid_nxt = cmd.emit | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_i_r     <= ACC_RESET;
      acc_q_r     <= ACC_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.upd) begin
        acc_i_r <= acc_i_nxt;
        acc_q_r <= acc_q_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw_i_r <= in_data.raw_i;
      raw_q_r <= in_data.raw_q;
    end
    if (cmd.rem) begin
      si_r   <= diff_i;
      sq_r   <= diff_q;
      over_r <= cfg.ovr_enable & ~diff_i[15] &
                (diff_i[14:0] > {4'd0, cfg.ovr_thresh});
    end
    if (cmd.mag) begin
      strength_r <= strength_nxt;
      quo_r      <= {1'b0, cfg.agc_top};
      rem_r      <= '0;
    end
    if (cmd.div_step) begin
      quo_r <= {quo_r[13:0], ge1, ge2};
      rem_r <= r2[12:0];
    end
    if (cmd.gain) begin
      scale_r <= scale_nxt;
      gs_r    <= gs_full[15:0];
    end
    if (cmd.emit) begin
      out_r.scaled_i        <= prod_i[15:0];
      out_r.scaled_q        <= prod_q[15:0];
      out_r.ovr_flag        <= over_r;
      out_r.signal_strength <= strength_r;
      out_r.agc_scale       <= scale_r;
    end
  end

  assign out_data        = out_r;
  assign out_valid       = out_valid_r;
  assign status.out_free = ~out_valid_r | out_ready;

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("output register not valid after emit");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |=> rem_r < strength_r)
    else $error("divider remainder not below divisor");

  a_out_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_r.signal_strength != '0 && out_r.agc_scale != '0)
    else $error("strength or scale emitted as zero");

endmodule

`default_nettype wire
